[design/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define RPIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RPIT_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/rpit_pkg.sv]
// ----------------------------------------------------------------------------
// rpit_pkg
// Widths, register indexes and limits of the recurrence integrality tester.
// ----------------------------------------------------------------------------
package rpit_pkg;

  localparam int MOD_W      = 64;
  localparam int COEF_W     = 41;
  localparam int NUM_COEF   = 6;
  localparam int PRIME_W    = 7;
  localparam int TERM_W     = 9;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 248;
  localparam int OUT_DATA_W = 8;

  localparam logic [TERM_W-1:0]  MAX_TERMS   = 9'd256;
  localparam logic [MOD_W-1:0]   MOD_RESET   = 64'd2;
  localparam logic [PRIME_W-1:0] PRIME_RESET = 7'd2;
  localparam logic [TERM_W-1:0]  TERM_RESET  = 9'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS    = 2'd0,
    CFG_PRIME      = 2'd1,
    CFG_TERM_COUNT = 2'd2
  } cfg_idx_e;

endpackage

[design/recurrence_padic_integrality_test_unit.sv]
// ----------------------------------------------------------------------------
// recurrence_padic_integrality_test_unit
// Runs A(n+1) = P(n)A(n) - n^2 Q(n)A(n-1) modulo a configured modulus and
// checks each nonzero term for divisibility by prime^(2 v_p((n+1)!)).
// ----------------------------------------------------------------------------
// Channel  | dir | contents
// s_axis   | in  | tdata: p_quad, p_lin, p_const, q_quad, q_lin, q_const
// m_axis   | out | tdata: pass
// cfg      | in  | modulus, prime, term_count writes
//
// One transaction at a time; multiplies, reductions and divisions by prime
// run bit-serially on shared shift and accumulator registers, a reduction
// or a division by prime at one cycle per bit.
// Reset clears control and restores register defaults. A result waiting on
// m_axis stalls only the end of the following transaction.
// ----------------------------------------------------------------------------
module recurrence_padic_integrality_test_unit
  import rpit_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // p_quad, p_lin, p_const, q_quad, q_lin, q_const (41 b each), 2 b zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pass, 7 b zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [MOD_W-1:0]      cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEQ, ST_RED, ST_MUL, ST_DIV, ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_RED_COEF, OP_STORE_COEF, OP_RED_ONE, OP_START, OP_NR, OP_NN,
    OP_M_BNR, OP_ADD_PV, OP_ADD_PV2, OP_M_DNN, OP_M_ENR, OP_ADD_QV,
    OP_ADD_QV2, OP_M_NNQ, OP_M_PREV, OP_M_PCUR, OP_SUB, OP_KCHK,
    OP_XCHK, OP_VAL, OP_ADV, OP_M_ANN
  } op_e;

  function automatic logic [MOD_W-1:0] add_mod(input logic [MOD_W-1:0] x,
                                               input logic [MOD_W-1:0] y,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (m != '0 && s >= {1'b0, m}) s = s - {1'b0, m};
    return s[MOD_W-1:0];
  endfunction

  function automatic logic [MOD_W-1:0] sub_mod(input logic [MOD_W-1:0] x,
                                               input logic [MOD_W-1:0] y,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] d;
    d = x - y;
    if (m != '0 && x < y) d = d + m;
    return d;
  endfunction

  // one bit of a residue reduction: (2r + b) mod m, with r < m
  function automatic logic [MOD_W-1:0] fold(input logic [MOD_W-1:0] r,
                                            input logic b,
                                            input logic [MOD_W-1:0] m);
    logic [MOD_W:0] s;
    s = {r, b};
    if (m != '0 && s >= {1'b0, m}) s = s - {1'b0, m};
    return s[MOD_W-1:0];
  endfunction

  state_e state_q;
  op_e    op_q;

  logic [MOD_W-1:0]   mod_q;
  logic [PRIME_W-1:0] prime_q;
  logic [TERM_W-1:0]  tc_q;

  logic [COEF_W-1:0] coef_q [NUM_COEF];
  logic [MOD_W-1:0]  res_q  [NUM_COEF];
  logic [2:0]        j_q;
  logic [MOD_W-1:0]  prev_q, cur_q, nr_q, nn_q, t_q, u_q, pv_q;
  logic [TERM_W-1:0] n_q, vf_q;
  logic [CNT_W-1:0]  v_q;
  logic              ok_q;

  // shared serial unit
  logic [MOD_W-1:0]   sh_q, acc_q, mx_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               neg_q, ph_q;
  logic [PRIME_W-1:0] rem_q;

  logic               m_tvalid_q, pass_q;

  logic [PRIME_W-1:0] p_eff;
  logic [TERM_W-1:0]  nmax;
  logic [TERM_W-1:0]  k_val;
  logic [15:0]        nsq;
  logic [COEF_W-1:0]  coef_sel, coef_mag;
  logic [PRIME_W:0]   rem2;
  logic               qbit;
  logic [TERM_W:0]    need;

  assign p_eff    = (prime_q < PRIME_W'(2)) ? PRIME_W'(2) : prime_q;
  assign nmax     = (tc_q > MAX_TERMS) ? MAX_TERMS : tc_q;
  assign k_val    = n_q + TERM_W'(1);
  assign nsq      = n_q[7:0] * n_q[7:0];
  assign coef_sel = coef_q[j_q];
  assign coef_mag = coef_sel[COEF_W-1] ? (COEF_W'(0) - coef_sel) : coef_sel;
  assign rem2     = {rem_q, sh_q[MOD_W-1]};
  assign qbit     = (rem2 >= {1'b0, p_eff});
  assign need     = {vf_q, 1'b0};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {7'b0, pass_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= OP_RED_COEF;
      mod_q      <= MOD_RESET;
      prime_q    <= PRIME_RESET;
      tc_q       <= TERM_RESET;
      m_tvalid_q <= 1'b0;
      pass_q     <= 1'b0;
      j_q        <= '0;
      n_q        <= '0;
      vf_q       <= '0;
      v_q        <= '0;
      ok_q       <= 1'b0;
      cnt_q      <= '0;
      neg_q      <= 1'b0;
      ph_q       <= 1'b0;
      rem_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MODULUS:    mod_q   <= cfg_data_i;
          CFG_PRIME:      prime_q <= cfg_data_i[PRIME_W-1:0];
          CFG_TERM_COUNT: tc_q    <= cfg_data_i[TERM_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_q && m_axis_tready) m_tvalid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            for (int i = 0; i < NUM_COEF; i++)
              coef_q[i] <= s_axis_tdata[i*COEF_W +: COEF_W];
            j_q     <= '0;
            op_q    <= OP_RED_COEF;
            state_q <= ST_SEQ;
          end
        end

        ST_RED: begin
          if (cnt_q != '0) begin
            acc_q <= fold(acc_q, sh_q[MOD_W-1], mod_q);
            sh_q  <= {sh_q[MOD_W-2:0], 1'b0};
            cnt_q <= cnt_q - CNT_W'(1);
          end else begin
            if (neg_q && acc_q != '0) acc_q <= mod_q - acc_q;
            state_q <= ST_SEQ;
          end
        end

        ST_MUL: begin
          if (!ph_q) begin
            acc_q <= add_mod(acc_q, acc_q, mod_q);
            ph_q  <= 1'b1;
          end else begin
            if (sh_q[MOD_W-1]) acc_q <= add_mod(acc_q, mx_q, mod_q);
            sh_q  <= {sh_q[MOD_W-2:0], 1'b0};
            cnt_q <= cnt_q - CNT_W'(1);
            ph_q  <= 1'b0;
            if (cnt_q == CNT_W'(1)) state_q <= ST_SEQ;
          end
        end

        ST_DIV: begin
          // restoring division by prime, quotient shifts in at the bottom
          rem_q <= qbit ? PRIME_W'(rem2 - {1'b0, p_eff}) : rem2[PRIME_W-1:0];
          sh_q  <= {sh_q[MOD_W-2:0], qbit};
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) state_q <= ST_SEQ;
        end

        ST_DONE: begin
          if (!m_tvalid_q) begin
            m_tvalid_q <= 1'b1;
            pass_q     <= ok_q;
            state_q    <= ST_IDLE;
          end
        end

        ST_SEQ: begin
          unique case (op_q)
            OP_RED_COEF: begin
              sh_q    <= {coef_mag, {(MOD_W-COEF_W){1'b0}}};
              cnt_q   <= CNT_W'(COEF_W);
              neg_q   <= coef_sel[COEF_W-1];
              acc_q   <= '0;
              op_q    <= OP_STORE_COEF;
              state_q <= ST_RED;
            end
            OP_STORE_COEF: begin
              res_q[j_q] <= acc_q;
              if (j_q == 3'(NUM_COEF-1)) begin
                op_q <= OP_RED_ONE;
              end else begin
                j_q  <= j_q + 3'd1;
                op_q <= OP_RED_COEF;
              end
            end
            OP_RED_ONE: begin
              sh_q    <= {1'b1, {(MOD_W-1){1'b0}}};
              cnt_q   <= CNT_W'(1);
              neg_q   <= 1'b0;
              acc_q   <= '0;
              op_q    <= OP_START;
              state_q <= ST_RED;
            end
            OP_START: begin
              prev_q <= acc_q;
              cur_q  <= res_q[2];
              n_q    <= TERM_W'(1);
              vf_q   <= '0;
              ok_q   <= 1'b1;
              if (nmax <= TERM_W'(1)) state_q <= ST_DONE;
              else op_q <= OP_NR;
            end
            OP_NR: begin
              sh_q    <= {n_q, {(MOD_W-TERM_W){1'b0}}};
              cnt_q   <= CNT_W'(TERM_W);
              neg_q   <= 1'b0;
              acc_q   <= '0;
              op_q    <= OP_NN;
              state_q <= ST_RED;
            end
            OP_NN: begin
              nr_q    <= acc_q;
              sh_q    <= {nsq, {(MOD_W-16){1'b0}}};
              cnt_q   <= CNT_W'(16);
              acc_q   <= '0;
              op_q    <= OP_M_ANN;
              state_q <= ST_RED;
            end
            OP_M_ANN: begin
              nn_q    <= acc_q;
              mx_q    <= res_q[0];
              sh_q    <= acc_q;
              cnt_q   <= CNT_W'(MOD_W);
              ph_q    <= 1'b0;
              acc_q   <= '0;
              op_q    <= OP_M_BNR;
              state_q <= ST_MUL;
            end
            OP_M_BNR: begin
              t_q     <= acc_q;
              mx_q    <= res_q[1];
              sh_q    <= nr_q;
              cnt_q   <= CNT_W'(MOD_W);
              acc_q   <= '0;
              op_q    <= OP_ADD_PV;
              state_q <= ST_MUL;
            end
            OP_ADD_PV: begin
              t_q  <= add_mod(t_q, acc_q, mod_q);
              op_q <= OP_ADD_PV2;
            end
            OP_ADD_PV2: begin
              pv_q <= add_mod(t_q, res_q[2], mod_q);
              op_q <= OP_M_DNN;
            end
            OP_M_DNN: begin
              mx_q    <= res_q[3];
              sh_q    <= nn_q;
              cnt_q   <= CNT_W'(MOD_W);
              acc_q   <= '0;
              op_q    <= OP_M_ENR;
              state_q <= ST_MUL;
            end
            OP_M_ENR: begin
              t_q     <= acc_q;
              mx_q    <= res_q[4];
              sh_q    <= nr_q;
              cnt_q   <= CNT_W'(MOD_W);
              acc_q   <= '0;
              op_q    <= OP_ADD_QV;
              state_q <= ST_MUL;
            end
            OP_ADD_QV: begin
              t_q  <= add_mod(t_q, acc_q, mod_q);
              op_q <= OP_ADD_QV2;
            end
            OP_ADD_QV2: begin
              t_q  <= add_mod(t_q, res_q[5], mod_q);
              op_q <= OP_M_NNQ;
            end
            OP_M_NNQ: begin
              mx_q    <= nn_q;
              sh_q    <= t_q;
              cnt_q   <= CNT_W'(MOD_W);
              acc_q   <= '0;
              op_q    <= OP_M_PREV;
              state_q <= ST_MUL;
            end
            OP_M_PREV: begin
              mx_q    <= acc_q;
              sh_q    <= prev_q;
              cnt_q   <= CNT_W'(MOD_W);
              acc_q   <= '0;
              op_q    <= OP_M_PCUR;
              state_q <= ST_MUL;
            end
            OP_M_PCUR: begin
              t_q     <= acc_q;
              mx_q    <= pv_q;
              sh_q    <= cur_q;
              cnt_q   <= CNT_W'(MOD_W);
              acc_q   <= '0;
              op_q    <= OP_SUB;
              state_q <= ST_MUL;
            end
            OP_SUB: begin
              u_q     <= sub_mod(acc_q, t_q, mod_q);
              sh_q    <= {k_val, {(MOD_W-TERM_W){1'b0}}};
              cnt_q   <= CNT_W'(TERM_W);
              rem_q   <= '0;
              op_q    <= OP_KCHK;
              state_q <= ST_DIV;
            end
            OP_KCHK: begin
              // strip factors of prime from n+1 into the factorial valuation
              if (rem_q == '0) begin
                vf_q    <= vf_q + TERM_W'(1);
                sh_q    <= {sh_q[TERM_W-1:0], {(MOD_W-TERM_W){1'b0}}};
                cnt_q   <= CNT_W'(TERM_W);
                state_q <= ST_DIV;
              end else begin
                op_q <= OP_VAL;
              end
            end
            OP_VAL: begin
              if (need != '0 && u_q != '0) begin
                v_q     <= '0;
                sh_q    <= u_q;
                cnt_q   <= CNT_W'(MOD_W);
                rem_q   <= '0;
                op_q    <= OP_XCHK;
                state_q <= ST_DIV;
              end else begin
                op_q <= OP_ADV;
              end
            end
            OP_XCHK: begin
              if (rem_q == '0) begin
                v_q <= v_q + CNT_W'(1);
                if ({3'b0, v_q} + (TERM_W+1)'(1) < need) begin
                  cnt_q   <= CNT_W'(MOD_W);
                  state_q <= ST_DIV;
                end else begin
                  op_q <= OP_ADV;
                end
              end else begin
                ok_q    <= 1'b0;
                state_q <= ST_DONE;
              end
            end
            OP_ADV: begin
              prev_q <= cur_q;
              cur_q  <= u_q;
              n_q    <= k_val;
              if (k_val < nmax) op_q <= OP_NR;
              else state_q <= ST_DONE;
            end
            default: state_q <= ST_DONE;
          endcase
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/rpit_checker.sv]
// ----------------------------------------------------------------------------
// rpit_checker
// Port-level checks of the recurrence integrality tester.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpit_checker
  import rpit_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // a result waits until taken
  `RPIT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")

  // one transaction at a time: busy right after an accept
  `RPIT_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")

  // a result only appears at the end of work, never straight out of idle
  `RPIT_ASSERT(a_result_from_work, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result without work")

  `RPIT_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:1] == '0, "nonzero padding")

  `RPIT_ASSERT_ANY(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "result during reset")

endmodule

bind recurrence_padic_integrality_test_unit rpit_checker u_rpit_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
